FILE: rtl/dlqm_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Doubly linked queue manager package
// Shared field widths, operation codes and controller/datapath interface types.
// -----------------------------------------------------------------------------
package dlqm_pkg;

   localparam int KIND_W           = 3;
   localparam int FIELD_W          = 8;
   localparam int NODE_COUNT_DEF   = 256;

   localparam logic [KIND_W-1:0] KIND_INS_AFTER  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_BEFORE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEQ_HEAD   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEQ_TAIL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNLINK     = 3'd4;

   // Phase commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic lookup;
      logic write1;
      logic write2;
      logic respond;
   } dlqm_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clear_last;
      logic do_write;
      logic two_writes;
      logic out_busy;
   } dlqm_status_type;

endpackage

FILE: rtl/dlqm_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Doubly linked queue manager controller
// Sequences the clearing pass and the lookup, write and respond phases.
// -----------------------------------------------------------------------------
module dlqm_ctrl
   import dlqm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dlqm_status_type status,
   output dlqm_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_WRITE1,
      ST_WRITE2,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = status.do_write ? ST_WRITE1 : ST_RESPOND;
         end
         ST_WRITE1: begin
            state_in = status.two_writes ? ST_WRITE2 : ST_RESPOND;
         end
         ST_WRITE2: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall   = stall_ff;
   assign cmd.clear   = (state_ff == ST_CLEAR);
   assign cmd.accept  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.write1  = (state_ff == ST_WRITE1);
   assign cmd.write2  = (state_ff == ST_WRITE2);
   assign cmd.respond = (state_ff == ST_RESPOND);

endmodule

FILE: rtl/dlqm_dpath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Doubly linked queue manager datapath
// Link memories, operand registers, link update logic and the result register.
// -----------------------------------------------------------------------------
module dlqm_dpath
   import dlqm_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  dlqm_cmd_type       cmd,
   output dlqm_status_type    status,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [FIELD_W-1:0] req_anchor_node,
   input  logic [FIELD_W-1:0] req_item_node,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_result_node,
   output logic               rsp_list_empty
);

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int WIDE_W = (NODE_W > FIELD_W) ? NODE_W : FIELD_W;

   function automatic logic [NODE_W-1:0] to_idx(input logic [FIELD_W-1:0] v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[NODE_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input logic [NODE_W-1:0] n);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(n);
      return w[FIELD_W-1:0];
   endfunction

   function automatic logic in_pool(input logic [FIELD_W-1:0] v);
      return 32'(v) < 32'(NODE_COUNT);
   endfunction

   logic [NODE_W-1:0] next_mem [NODE_COUNT];
   logic [NODE_W-1:0] prev_mem [NODE_COUNT];

   logic [NODE_W-1:0]  rd_next_ff, rd_prev_ff;
   logic [NODE_W-1:0]  raddr;
   logic [NODE_W-1:0]  clr_ff;

   logic [KIND_W-1:0]  kind_ff;
   logic [NODE_W-1:0]  anchor_ff, item_ff;
   logic               ok_ff, ok_in;
   logic [NODE_W-1:0]  x_next_ff, x_prev_ff;

   logic [NODE_W-1:0]  elem;
   logic               elem_empty;
   logic               is_deq;
   logic [FIELD_W-1:0] res_in;
   logic               empty_in;
   logic [FIELD_W-1:0] res_ff;
   logic               empty_ff;

   logic               wn_en, wp_en;
   logic [NODE_W-1:0]  wn_addr, wn_data, wp_addr, wp_data;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_node_ff;
   logic               rsp_empty_ff;
   logic               out_load;

   // Clearing pass counter; the controller leaves the clear phase on the last entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Operation is performed only for a defined kind whose nodes are in the pool.
   always_comb begin
      case (req_kind)
         KIND_INS_AFTER, KIND_INS_BEFORE: ok_in = in_pool(req_anchor_node) &&
                                                  in_pool(req_item_node);
         KIND_DEQ_HEAD, KIND_DEQ_TAIL:    ok_in = in_pool(req_anchor_node);
         KIND_UNLINK:                     ok_in = in_pool(req_item_node);
         default:                         ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_kind;
         anchor_ff <= to_idx(req_anchor_node);
         item_ff   <= to_idx(req_item_node);
         ok_ff     <= ok_in;
      end
   end

   // The first read addresses the anchor (the item for unlink); the second
   // read, issued during lookup, addresses the node a dequeue removes.
   assign is_deq     = (kind_ff == KIND_DEQ_HEAD) || (kind_ff == KIND_DEQ_TAIL);
   assign elem       = (kind_ff == KIND_DEQ_TAIL) ? rd_prev_ff : rd_next_ff;
   assign elem_empty = (elem == anchor_ff);
   assign raddr      = cmd.lookup ? elem :
                       ((req_kind == KIND_UNLINK) ? to_idx(req_item_node)
                                                  : to_idx(req_anchor_node));

   always_comb begin
      res_in   = '0;
      empty_in = 1'b0;
      if (ok_ff) begin
         if (is_deq) begin
            empty_in = elem_empty;
            res_in   = elem_empty ? '0 : to_field(elem);
         end else if (kind_ff == KIND_UNLINK) begin
            res_in = to_field(item_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         x_next_ff <= rd_next_ff;
         x_prev_ff <= rd_prev_ff;
         res_ff    <= res_in;
         empty_ff  <= empty_in;
      end
   end

   assign status.clear_last = (clr_ff == NODE_W'(NODE_COUNT - 1));
   assign status.do_write   = ok_ff && !(is_deq && elem_empty);
   assign status.two_writes = (kind_ff == KIND_INS_AFTER) || (kind_ff == KIND_INS_BEFORE);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   // Link writes. Within each memory the writes keep the order of the
   // operation's update sequence, so aliased anchor and item resolve alike.
   always_comb begin
      wn_en   = 1'b0;
      wp_en   = 1'b0;
      wn_addr = clr_ff;
      wn_data = clr_ff;
      wp_addr = clr_ff;
      wp_data = clr_ff;
      if (cmd.clear) begin
         wn_en = 1'b1;
         wp_en = 1'b1;
      end else if (cmd.write1) begin
         case (kind_ff)
            KIND_INS_AFTER: begin
               wn_en = 1'b1; wn_addr = item_ff;   wn_data = x_next_ff;
               wp_en = 1'b1; wp_addr = item_ff;   wp_data = anchor_ff;
            end
            KIND_INS_BEFORE: begin
               wn_en = 1'b1; wn_addr = item_ff;   wn_data = anchor_ff;
               wp_en = 1'b1; wp_addr = item_ff;   wp_data = x_prev_ff;
            end
            KIND_DEQ_HEAD: begin
               wp_en = 1'b1; wp_addr = rd_next_ff; wp_data = anchor_ff;
               wn_en = 1'b1; wn_addr = anchor_ff;  wn_data = rd_next_ff;
            end
            KIND_DEQ_TAIL: begin
               wn_en = 1'b1; wn_addr = rd_prev_ff; wn_data = anchor_ff;
               wp_en = 1'b1; wp_addr = anchor_ff;  wp_data = rd_prev_ff;
            end
            KIND_UNLINK: begin
               wp_en = 1'b1; wp_addr = x_next_ff; wp_data = x_prev_ff;
               wn_en = 1'b1; wn_addr = x_prev_ff; wn_data = x_next_ff;
            end
            default: begin
               wn_en = 1'b0;
            end
         endcase
      end else if (cmd.write2) begin
         case (kind_ff)
            KIND_INS_AFTER: begin
               wn_en = 1'b1; wn_addr = anchor_ff; wn_data = item_ff;
               wp_en = 1'b1; wp_addr = x_next_ff; wp_data = item_ff;
            end
            KIND_INS_BEFORE: begin
               wn_en = 1'b1; wn_addr = x_prev_ff; wn_data = item_ff;
               wp_en = 1'b1; wp_addr = anchor_ff; wp_data = item_ff;
            end
            default: begin
               wn_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wn_en) next_mem[wn_addr] <= wn_data;
      if (wp_en) prev_mem[wp_addr] <= wp_data;
      rd_next_ff <= next_mem[raddr];
      rd_prev_ff <= prev_mem[raddr];
   end

   // Result register; a new result loads only once the previous one is taken.
   assign out_load = cmd.respond && !status.out_busy;

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_node_ff  <= res_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_node = rsp_node_ff;
   assign rsp_list_empty  = rsp_empty_ff;

endmodule

FILE: rtl/doubly_linked_queue_manager_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Doubly linked queue manager
// Circular doubly linked lists over a pool of nodes held as link indices.
// -----------------------------------------------------------------------------
// Usage: each request transaction carries one operation (insert after or
// before an anchor, dequeue at head or tail, unlink an item) and yields
// exactly one response transaction with the removed node (zero where none is removed) and an empty flag.
// Requests are taken one at a time. After a request is accepted, a lookup
// phase follows; an ignored operation or an empty dequeue then responds,
// a dequeue or unlink passes one write phase first, and an insert two; the
// next request can be accepted once the response is loaded. The phases are
// set by the next and previous link memories, each with one write port
// and a registered read: a dequeue needs two dependent reads, and an
// insert writes two entries of each memory.
// After reset, a clearing pass links every node to itself, one node per
// cycle, with req_stall held high.
// A finished response waits in an output register while rsp_stall is high;
// the next request may be accepted meanwhile, but its response is held
// until the waiting one is taken.
// -----------------------------------------------------------------------------
module doubly_linked_queue_manager_unit
   import dlqm_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [FIELD_W-1:0] req_anchor_node,
   input  logic [FIELD_W-1:0] req_item_node,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_result_node,
   output logic               rsp_list_empty
);

   dlqm_cmd_type    cmd;
   dlqm_status_type status;

   dlqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dlqm_dpath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_anchor_node (req_anchor_node),
      .req_item_node   (req_item_node),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_node (rsp_result_node),
      .rsp_list_empty  (rsp_list_empty)
   );

endmodule

FILE: rtl/dlqm_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Doubly linked queue manager checker
// Port-level properties of the queue manager, bound to the top level.
// -----------------------------------------------------------------------------
module dlqm_checker
   import dlqm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [KIND_W-1:0]  req_kind,
   input logic [FIELD_W-1:0] req_anchor_node,
   input logic [FIELD_W-1:0] req_item_node,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [FIELD_W-1:0] rsp_result_node,
   input logic               rsp_list_empty
);

   // The clearing pass keeps requests out right after reset.
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("request side open or response valid after reset");

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while one is in progress");

   // A stalled request transaction is held until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_kind) &&
                                 $stable(req_anchor_node) && $stable(req_item_node))
      else $error("stalled request transaction changed");

   // An empty dequeue always reports node zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_empty |-> rsp_result_node == '0)
      else $error("empty response carries a nonzero node");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_node) &&
                                 $stable(rsp_list_empty))
      else $error("stalled response transaction changed");

endmodule

bind doubly_linked_queue_manager_unit dlqm_checker u_dlqm_checker (.*);
